### sv/prq_pkg.sv
// shared types and constants of the packet ring queue
package prq_pkg;

  localparam int unsigned QUEUE_DEPTH      = 16;
  localparam int unsigned MAX_PACKET_BYTES = 1024;

  localparam int unsigned PTR_W    = $clog2(QUEUE_DEPTH);
  localparam int unsigned OCC_W    = PTR_W + 1;
  localparam int unsigned ADDR_W   = $clog2(QUEUE_DEPTH * MAX_PACKET_BYTES);
  localparam int unsigned STORED_W = $clog2(MAX_PACKET_BYTES + 1);
  localparam int unsigned LEN_W    = 16;
  localparam logic [LEN_W-1:0] LEN_SAT = '1;

  typedef enum logic [2:0] {
    CMD_PUSH  = 3'd0,
    CMD_PEEK  = 3'd1,
    CMD_FREE  = 3'd2,
    CMD_BUSY  = 3'd3,
    CMD_STATS = 3'd4
  } cmd_e;

  typedef struct packed {
    logic [2:0] cmd;
    logic [7:0] pkt_type;
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       last_byte;
    logic [9:0] read_index;
  } in_item_t;

  typedef struct packed {
    logic        ok;
    logic        empty_res;
    logic [7:0]  head_type;
    logic [10:0] head_size;
    logic [7:0]  read_value;
    logic [31:0] total_count;
    logic [31:0] drop_count;
    logic [7:0]  max_depth;
    logic [31:0] byte_count;
    logic [31:0] busy_count;
    logic [7:0]  depth_now;
  } out_item_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [7:0]        wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

  typedef struct packed {
    logic [OCC_W-1:0] depth;
    logic             empty;
  } status_t;

endpackage

### sv/prq_byte_ram.sv
// packet byte storage: one write port, one read port with registered data
module prq_byte_ram (
  input  logic              clk_i,
  input  prq_pkg::mem_req_t req_i,
  output logic [7:0]        rdata_o
);
  import prq_pkg::*;

  logic [7:0] mem [QUEUE_DEPTH * MAX_PACKET_BYTES];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rdata_q <= mem[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### sv/prq_core.sv
// ring pointers, packet assembly, slot descriptors and statistics counters
module prq_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  prq_pkg::in_item_t   item_i,
  output prq_pkg::out_item_t  res_o,
  output logic                rd_hit_o,
  output prq_pkg::mem_req_t   mem_req_o,
  output prq_pkg::status_t    status_o
);
  import prq_pkg::*;

  logic [PTR_W-1:0]    wp_q, wp_d, rp_q, rp_d;
  logic [LEN_W-1:0]    len_q, len_d;
  logic                drop_q, drop_d;
  logic [31:0]         acc_q, acc_d, dropped_q, dropped_d;
  logic [31:0]         bytes_q, bytes_d, busy_q, busy_d;
  logic [7:0]          peak_q, peak_d;

  logic [7:0]          types_q [QUEUE_DEPTH];
  logic [STORED_W-1:0] sizes_q [QUEUE_DEPTH];

  logic                type_we, size_we;
  logic [STORED_W-1:0] size_wdata;
  logic [OCC_W-1:0]    occ, depth_new;
  logic [PTR_W-1:0]    wp_inc, rp_inc;
  logic                empty_now, full_now;
  logic [LEN_W-1:0]    len_inc;

  always_comb begin
    if (wp_q >= rp_q) begin
      occ = OCC_W'(wp_q) - OCC_W'(rp_q);
    end else begin
      occ = OCC_W'(wp_q) + OCC_W'(QUEUE_DEPTH) - OCC_W'(rp_q);
    end
  end

  assign wp_inc    = (wp_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wp_q + 1'b1;
  assign rp_inc    = (rp_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rp_q + 1'b1;
  assign empty_now = (wp_q == rp_q);
  assign full_now  = (wp_inc == rp_q);
  assign depth_new = occ + 1'b1;

  always_comb begin
    wp_d       = wp_q;
    rp_d       = rp_q;
    len_d      = len_q;
    drop_d     = drop_q;
    acc_d      = acc_q;
    dropped_d  = dropped_q;
    bytes_d    = bytes_q;
    busy_d     = busy_q;
    peak_d     = peak_q;
    type_we    = 1'b0;
    size_we    = 1'b0;
    size_wdata = '0;
    len_inc    = len_q;
    res_o      = '0;
    rd_hit_o   = 1'b0;
    mem_req_o  = '0;

    unique case (cmd_e'(item_i.cmd))
      CMD_PUSH: begin
        if (!item_i.byte_valid && !item_i.last_byte) begin
          res_o.ok = !drop_q;
        end else begin
          // first item of a packet decides accept or drop
          if (len_q == '0 && !drop_q) begin
            if (full_now) begin
              drop_d    = 1'b1;
              dropped_d = dropped_q + 1'b1;
            end else begin
              type_we = 1'b1;
            end
          end
          res_o.ok = !drop_d;
          if (item_i.byte_valid) begin
            if (!drop_d && len_q < LEN_W'(MAX_PACKET_BYTES)) begin
              mem_req_o.we    = 1'b1;
              mem_req_o.waddr = ADDR_W'(wp_q) * ADDR_W'(MAX_PACKET_BYTES) + ADDR_W'(len_q);
              mem_req_o.wdata = item_i.data_byte;
            end
            if (len_q != LEN_SAT) begin
              len_inc = len_q + 1'b1;
            end
          end
          len_d = len_inc;
          if (item_i.last_byte) begin
            if (!drop_d) begin
              acc_d   = acc_q + 1'b1;
              bytes_d = bytes_q + 32'(len_inc);
              if (8'(depth_new) > peak_q) begin
                peak_d = 8'(depth_new);
              end
              size_we    = 1'b1;
              size_wdata = (len_inc > LEN_W'(MAX_PACKET_BYTES)) ?
                           STORED_W'(MAX_PACKET_BYTES) : STORED_W'(len_inc);
              wp_d       = wp_inc;
            end
            drop_d = 1'b0;
            len_d  = '0;
          end
        end
      end
      CMD_PEEK: begin
        if (!empty_now) begin
          res_o.ok        = 1'b1;
          res_o.head_type = types_q[rp_q];
          res_o.head_size = 11'(sizes_q[rp_q]);
          if (16'(item_i.read_index) < 16'(sizes_q[rp_q]) &&
              16'(item_i.read_index) < 16'(MAX_PACKET_BYTES)) begin
            rd_hit_o        = 1'b1;
            mem_req_o.re    = step_i;
            mem_req_o.raddr = ADDR_W'(rp_q) * ADDR_W'(MAX_PACKET_BYTES) +
                              ADDR_W'(item_i.read_index);
          end
        end
      end
      CMD_FREE: begin
        if (!empty_now) begin
          rp_d     = rp_inc;
          res_o.ok = 1'b1;
        end
      end
      CMD_BUSY: begin
        busy_d   = busy_q + 1'b1;
        res_o.ok = 1'b1;
      end
      CMD_STATS: begin
        res_o.ok          = 1'b1;
        res_o.total_count = acc_q;
        res_o.drop_count  = dropped_q;
        res_o.max_depth   = peak_q;
        res_o.byte_count  = bytes_q;
        res_o.busy_count  = busy_q;
        res_o.depth_now   = 8'(occ);
        acc_d     = '0;
        dropped_d = '0;
        peak_d    = '0;
        bytes_d   = '0;
        busy_d    = '0;
      end
      default: begin
        res_o.ok = 1'b0;
      end
    endcase

    res_o.empty_res = (wp_d == rp_d);
    // no side effects unless the item is really taken this cycle
    mem_req_o.we = mem_req_o.we & step_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q      <= '0;
      rp_q      <= '0;
      len_q     <= '0;
      drop_q    <= 1'b0;
      acc_q     <= '0;
      dropped_q <= '0;
      bytes_q   <= '0;
      busy_q    <= '0;
      peak_q    <= '0;
    end else if (step_i) begin
      wp_q      <= wp_d;
      rp_q      <= rp_d;
      len_q     <= len_d;
      drop_q    <= drop_d;
      acc_q     <= acc_d;
      dropped_q <= dropped_d;
      bytes_q   <= bytes_d;
      busy_q    <= busy_d;
      peak_q    <= peak_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i && type_we) begin
      types_q[wp_q] <= item_i.pkt_type;
    end
    if (step_i && size_we) begin
      sizes_q[wp_q] <= size_wdata;
    end
  end

  assign status_o.depth = occ;
  assign status_o.empty = empty_now;

endmodule

### sv/packet_ring_queue_with_stats.sv
// top level of the packet ring queue: input stage, result stage and checks
// Takes one command beat per cycle while the output is not stalled and returns one result
// beat for each: the beat is captured in an input register, the queue logic works on it
// once it is held there, and the result register together with the registered read port
// of the packet byte memory delivers it. Pushes, peeks, frees, busy marks and statistics
// reads may be mixed freely at full rate. The byte memory holds QUEUE_DEPTH slots of
// MAX_PACKET_BYTES bytes, needs no clearing after reset, and the ring holds at most
// QUEUE_DEPTH-1 packets since one slot is kept empty.
module packet_ring_queue_with_stats (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  prq_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output prq_pkg::out_item_t out_data_o
);
  import prq_pkg::*;

  logic      s1_valid_q;
  in_item_t  s1_item_q;
  logic      out_valid_q;
  out_item_t result_q;
  logic      hit_q;

  logic      advance, step;
  out_item_t core_res;
  logic      core_hit;
  mem_req_t  mem_req;
  logic [7:0] mem_rdata;
  status_t   status;

  assign advance    = !out_valid_q || !out_stall_i;
  assign step       = advance && s1_valid_q;
  assign in_stall_o = s1_valid_q && !advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (!in_stall_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      s1_item_q <= in_data_i;
    end
    if (step) begin
      result_q <= core_res;
      hit_q    <= core_hit;
    end
  end

  prq_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (step),
    .item_i    (s1_item_q),
    .res_o     (core_res),
    .rd_hit_o  (core_hit),
    .mem_req_o (mem_req),
    .status_o  (status)
  );

  prq_byte_ram u_ram (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

  // peek byte arrives from the memory read register alongside the result beat
  always_comb begin
    out_data_o            = result_q;
    out_data_o.read_value = hit_q ? mem_rdata : 8'h00;
  end

  assign out_valid_o = out_valid_q;

  a_stall_only_when_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled while output stage is free");

  a_depth_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.depth < OCC_W'(QUEUE_DEPTH) && status.empty == (status.depth == '0))
    else $error("ring occupancy reached the slot count");

  a_empty_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.empty_res) |-> (out_data_o.depth_now == 8'h00))
    else $error("empty result beat reports nonzero depth");

  a_no_head_when_not_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_data_o.ok) |->
      (out_data_o.read_value == 8'h00 && out_data_o.head_size == 11'd0))
    else $error("head fields set on a failed beat");

endmodule

### dv/testbench.sv
// self-checking testbench for the packet ring queue with statistics
`timescale 1ns / 100ps

module testbench;
  import prq_pkg::*;

  localparam logic [2:0] CMD_SPARE_LO = 3'd5;
  localparam logic [2:0] CMD_SPARE_HI = 3'd7;
  localparam longint unsigned RUN_LIMIT_NS = 200_000;

  typedef struct {
    in_item_t  beat;
    bit        typed;
    out_item_t want;
  } plan_row_t;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_stall_o;
  in_item_t  in_data_i;
  logic      out_valid_o;
  logic      out_stall_i;
  out_item_t out_data_o;

  packet_ring_queue_with_stats uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  // shadow copy of the queue contents and statistics
  logic [7:0]       held_bytes [QUEUE_DEPTH][MAX_PACKET_BYTES];
  logic [7:0]       held_type  [QUEUE_DEPTH];
  logic [10:0]      held_size  [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_slot, rd_slot;
  logic [LEN_W-1:0] rx_len;
  bit               rx_dropping;
  logic [31:0]      n_accepted, n_dropped, n_bytes, n_busy;
  logic [7:0]       peak_held;

  out_item_t   pending_responses [$];
  plan_row_t   plan [$];
  int unsigned gap_pct, stall_pct, n_sent;
  int          n_mismatch;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("FAIL packet_ring_queue_with_stats");
    $finish;
  end

  function automatic out_item_t ring_response(in_item_t b);
    out_item_t        r;
    logic [PTR_W-1:0] next_wr, held;
    r = '0;
    held = wr_slot - rd_slot;
    case (b.cmd)
      CMD_PUSH: begin
        if ((b.byte_valid || b.last_byte) && rx_len == '0 && !rx_dropping) begin
          next_wr = wr_slot + 1'b1;
          if (next_wr == rd_slot) begin
            rx_dropping = 1'b1;
            n_dropped++;
          end else begin
            held_type[wr_slot] = b.pkt_type;
          end
        end
        r.ok = !rx_dropping;
        if (b.byte_valid) begin
          if (!rx_dropping && rx_len < MAX_PACKET_BYTES)
            held_bytes[wr_slot][rx_len[9:0]] = b.data_byte;
          if (rx_len != LEN_SAT) rx_len++;
        end
        if (b.last_byte) begin
          if (!rx_dropping) begin
            // peak counts the packet being committed
            held = held + 1'b1;
            n_accepted++;
            n_bytes += 32'(rx_len);
            if (8'(held) > peak_held) peak_held = 8'(held);
            held_size[wr_slot] = (rx_len > MAX_PACKET_BYTES) ? 11'(MAX_PACKET_BYTES) : rx_len[10:0];
            wr_slot++;
          end
          rx_dropping = 1'b0;
          rx_len = '0;
        end
      end
      CMD_PEEK: begin
        if (wr_slot != rd_slot) begin
          r.ok = 1'b1;
          r.head_type = held_type[rd_slot];
          r.head_size = held_size[rd_slot];
          if (b.read_index < held_size[rd_slot]) r.read_value = held_bytes[rd_slot][b.read_index];
        end
      end
      CMD_FREE: begin
        if (wr_slot != rd_slot) begin
          rd_slot++;
          r.ok = 1'b1;
        end
      end
      CMD_BUSY: begin
        n_busy++;
        r.ok = 1'b1;
      end
      CMD_STATS: begin
        r.ok = 1'b1;
        r.total_count = n_accepted;
        r.drop_count = n_dropped;
        r.max_depth = peak_held;
        r.byte_count = n_bytes;
        r.busy_count = n_busy;
        r.depth_now = 8'(held);
        n_accepted = '0;
        n_dropped = '0;
        peak_held = '0;
        n_bytes = '0;
        n_busy = '0;
      end
      default: ;
    endcase
    r.empty_res = (wr_slot == rd_slot);
    return r;
  endfunction

  function automatic in_item_t mk_beat(logic [2:0] c, logic [7:0] ty, logic [7:0] d,
                                       bit v, bit l, logic [9:0] ix);
    in_item_t b;
    b.cmd = c;
    b.pkt_type = ty;
    b.data_byte = d;
    b.byte_valid = v;
    b.last_byte = l;
    b.read_index = ix;
    return b;
  endfunction

  function automatic out_item_t brief(bit ok, bit empty, logic [7:0] ty, logic [10:0] sz,
                                      logic [7:0] rv);
    out_item_t r;
    r = '0;
    r.ok = ok;
    r.empty_res = empty;
    r.head_type = ty;
    r.head_size = sz;
    r.read_value = rv;
    return r;
  endfunction

  function automatic void add_row(in_item_t b, bit typed, out_item_t want);
    plan_row_t row;
    row.beat = b;
    row.typed = typed;
    row.want = want;
    plan.push_back(row);
  endfunction

  // random reader-side command; peeks mostly land inside the head packet
  function automatic in_item_t reader_beat();
    int unsigned pick;
    logic [9:0]  ix;
    logic [2:0]  c;
    pick = $urandom_range(99);
    ix = 10'($urandom_range(1023));
    if (wr_slot != rd_slot && held_size[rd_slot] != '0 && $urandom_range(3) != 0)
      ix = 10'($urandom_range(int'(held_size[rd_slot]) - 1));
    if (pick < 40) c = CMD_PEEK;
    else if (pick < 70) c = CMD_FREE;
    else if (pick < 82) c = CMD_BUSY;
    else if (pick < 92) c = CMD_STATS;
    else c = 3'($urandom_range(CMD_SPARE_HI, CMD_SPARE_LO));
    return mk_beat(c, 8'($urandom_range(255)), 8'($urandom_range(255)),
                   1'($urandom_range(1)), 1'($urandom_range(1)), ix);
  endfunction

  task automatic drive_beat(in_item_t b, bit typed, out_item_t want);
    out_item_t r;
    while ($urandom_range(99) < gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= b;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    r = ring_response(b);
    pending_responses.push_back(typed ? want : r);
    n_sent++;
  endtask

  task automatic send_packet(int unsigned len, int unsigned mix_pct);
    logic [7:0] ty;
    bit         tail_empty;
    ty = 8'($urandom_range(255));
    // sometimes the last beat carries no byte
    tail_empty = (len != 0) && ($urandom_range(19) == 0);
    for (int unsigned i = 0; i < len; i++) begin
      if ($urandom_range(99) < mix_pct) drive_beat(reader_beat(), 1'b0, '0);
      if ($urandom_range(99) < mix_pct / 2)
        drive_beat(mk_beat(CMD_PUSH, 8'($urandom_range(255)), 8'($urandom_range(255)),
                           1'b0, 1'b0, 10'($urandom_range(1023))), 1'b0, '0);
      drive_beat(mk_beat(CMD_PUSH, (i == 0) ? ty : 8'($urandom_range(255)),
                         8'($urandom_range(255)), 1'b1, !tail_empty && i == len - 1,
                         10'($urandom_range(1023))), 1'b0, '0);
    end
    if (len == 0 || tail_empty)
      drive_beat(mk_beat(CMD_PUSH, ty, 8'($urandom_range(255)), 1'b0, 1'b1,
                         10'($urandom_range(1023))), 1'b0, '0);
  endtask

  task automatic random_traffic(int unsigned n_beats, int unsigned pkt_pct);
    int unsigned first, len, pick;
    first = n_sent;
    while (n_sent - first < n_beats) begin
      if ($urandom_range(99) < pkt_pct) begin
        pick = $urandom_range(199);
        if (pick < 180) len = $urandom_range(6);
        else if (pick < 198) len = $urandom_range(40, 7);
        else len = $urandom_range(64, 41);
        send_packet(len, 10);
      end else begin
        drive_beat(reader_beat(), 1'b0, '0);
      end
    end
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_responses.size() != 0);
  endtask

  task automatic free_all();
    while (wr_slot != rd_slot) drive_beat(mk_beat(CMD_FREE, 0, 0, 0, 0, 0), 1'b0, '0);
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      n_mismatch++;
    end
  endtask

  task automatic check_response(out_item_t want, out_item_t got);
    check_field("ok", 32'(want.ok), 32'(got.ok));
    check_field("empty_res", 32'(want.empty_res), 32'(got.empty_res));
    check_field("head_type", 32'(want.head_type), 32'(got.head_type));
    check_field("head_size", 32'(want.head_size), 32'(got.head_size));
    check_field("read_value", 32'(want.read_value), 32'(got.read_value));
    check_field("total_count", want.total_count, got.total_count);
    check_field("drop_count", want.drop_count, got.drop_count);
    check_field("max_depth", 32'(want.max_depth), 32'(got.max_depth));
    check_field("byte_count", want.byte_count, got.byte_count);
    check_field("busy_count", want.busy_count, got.busy_count);
    check_field("depth_now", 32'(want.depth_now), 32'(got.depth_now));
  endtask

  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      if (pending_responses.size() == 0) begin
        $error("result beat with no command waiting for it");
        n_mismatch++;
      end else begin
        check_response(pending_responses.pop_front(), out_data_o);
      end
    end
  end

  initial begin
    out_item_t st;
    rst_ni     <= 1'b0;
    in_valid_i <= 1'b0;
    in_data_i  <= '0;
    gap_pct = 0;
    stall_pct = 0;
    n_sent = 0;
    n_mismatch = 0;
    wr_slot = '0;
    rd_slot = '0;
    rx_len = '0;
    rx_dropping = 1'b0;
    n_accepted = '0;
    n_dropped = '0;
    n_bytes = '0;
    n_busy = '0;
    peak_held = '0;

    // directed table: cmd, type, byte, byte_valid, last_byte, index
    add_row(mk_beat(CMD_STATS, 0, 0, 0, 0, 0), 1'b1, brief(1, 1, 0, 0, 0));
    add_row(mk_beat(CMD_PEEK, 0, 0, 0, 0, 0), 1'b1, brief(0, 1, 0, 0, 0));
    add_row(mk_beat(CMD_FREE, 0, 0, 0, 0, 0), 1'b1, brief(0, 1, 0, 0, 0));
    add_row(mk_beat(CMD_SPARE_LO, 8'hff, 8'hff, 1, 1, 10'h3ff), 1'b1, brief(0, 1, 0, 0, 0));
    add_row(mk_beat(CMD_SPARE_HI, 8'hff, 8'hff, 1, 1, 10'h3ff), 1'b1, brief(0, 1, 0, 0, 0));
    add_row(mk_beat(CMD_BUSY, 0, 0, 0, 0, 0), 1'b1, brief(1, 1, 0, 0, 0));
    add_row(mk_beat(CMD_PUSH, 8'haa, 8'h55, 0, 0, 0), 1'b1, brief(1, 1, 0, 0, 0));
    // zero-length packet
    add_row(mk_beat(CMD_PUSH, 8'hff, 8'h00, 0, 1, 0), 1'b1, brief(1, 0, 0, 0, 0));
    add_row(mk_beat(CMD_PEEK, 0, 0, 0, 0, 10'h3ff), 1'b1, brief(1, 0, 8'hff, 0, 0));
    add_row(mk_beat(CMD_PUSH, 8'h00, 8'hff, 1, 0, 0), 1'b1, brief(1, 0, 0, 0, 0));
    add_row(mk_beat(CMD_BUSY, 0, 0, 0, 0, 0), 1'b1, brief(1, 0, 0, 0, 0));
    add_row(mk_beat(CMD_PEEK, 0, 0, 0, 0, 0), 1'b1, brief(1, 0, 8'hff, 0, 0));
    add_row(mk_beat(CMD_PUSH, 8'h5a, 8'h00, 1, 1, 0), 1'b1, brief(1, 0, 0, 0, 0));
    add_row(mk_beat(CMD_FREE, 0, 0, 0, 0, 0), 1'b1, brief(1, 0, 0, 0, 0));
    add_row(mk_beat(CMD_PEEK, 0, 0, 0, 0, 0), 1'b0, '0);
    add_row(mk_beat(CMD_PEEK, 0, 0, 0, 0, 1), 1'b0, '0);
    add_row(mk_beat(CMD_PEEK, 0, 0, 0, 0, 2), 1'b1, brief(1, 0, 8'h00, 2, 0));
    st = brief(1, 0, 0, 0, 0);
    st.total_count = 2;
    st.max_depth = 2;
    st.byte_count = 2;
    st.busy_count = 2;
    st.depth_now = 1;
    add_row(mk_beat(CMD_STATS, 0, 0, 0, 0, 0), 1'b1, st);
    add_row(mk_beat(CMD_PUSH, 8'h80, 8'h01, 1, 1, 0), 1'b0, '0);
    add_row(mk_beat(CMD_STATS, 0, 0, 0, 0, 0), 1'b0, '0);
    add_row(mk_beat(CMD_FREE, 0, 0, 0, 0, 0), 1'b1, brief(1, 0, 0, 0, 0));
    add_row(mk_beat(CMD_FREE, 0, 0, 0, 0, 0), 1'b1, brief(1, 1, 0, 0, 0));
    add_row(mk_beat(CMD_FREE, 0, 0, 0, 0, 0), 1'b1, brief(0, 1, 0, 0, 0));

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i]) drive_beat(plan[i].beat, plan[i].typed, plan[i].want);

    // fill the ring, then drop whole packets with reader beats in between
    repeat (QUEUE_DEPTH - 1) send_packet(1, 0);
    drive_beat(mk_beat(CMD_PUSH, 8'h3c, 8'($urandom_range(255)), 1, 0, 0), 1'b0, '0);
    drive_beat(mk_beat(CMD_PEEK, 0, 0, 0, 0, 0), 1'b0, '0);
    drive_beat(mk_beat(CMD_PUSH, 0, 0, 0, 0, 0), 1'b0, '0);
    drive_beat(mk_beat(CMD_FREE, 0, 0, 0, 0, 0), 1'b0, '0);
    drive_beat(mk_beat(CMD_STATS, 0, 0, 0, 0, 0), 1'b0, '0);
    drive_beat(mk_beat(CMD_PUSH, 0, 8'($urandom_range(255)), 1, 1, 0), 1'b0, '0);
    drive_beat(mk_beat(CMD_FREE, 0, 0, 0, 0, 0), 1'b0, '0);
    send_packet(2, 0);
    drive_beat(mk_beat(CMD_PUSH, 8'h77, 0, 0, 1, 0), 1'b0, '0);
    drive_beat(mk_beat(CMD_STATS, 0, 0, 0, 0, 0), 1'b0, '0);

    // longer packet: peeks beyond the stored bytes and at a random index
    free_all();
    send_packet(40, 0);
    drive_beat(mk_beat(CMD_PEEK, 0, 0, 0, 0, 10'h3ff), 1'b0, '0);
    drive_beat(mk_beat(CMD_PEEK, 0, 0, 0, 0, 10'($urandom_range(1023))), 1'b0, '0);
    drive_beat(mk_beat(CMD_FREE, 0, 0, 0, 0, 0), 1'b0, '0);
    drive_beat(mk_beat(CMD_STATS, 0, 0, 0, 0, 0), 1'b0, '0);
    free_all();

    // hold off until the queue has answered everything
    wait_drained();

    random_traffic(100, 60);
    gap_pct = 51;
    random_traffic(100, 30);
    wait_drained();
    gap_pct = 0;
    stall_pct = 51;
    random_traffic(100, 20);
    gap_pct = 16;
    stall_pct = 16;
    random_traffic(100, 45);

    wait_drained();
    repeat (8) @(posedge clk_i);
    if (n_mismatch == 0) $display("PASS packet_ring_queue_with_stats");
    else $display("FAIL packet_ring_queue_with_stats");
    $finish;
  end

endmodule

### filelist.f
sv/prq_pkg.sv
sv/prq_byte_ram.sv
sv/prq_core.sv
sv/packet_ring_queue_with_stats.sv
dv/testbench.sv
